>>> rtl/pfd_pkg.sv
// Package for the prefixed frame deframer: frame byte codes, field widths
// and payload store geometry.
// No dependencies.
package pfd_pkg;

   // Basic widths
   localparam int BYTE_W   = 8;
   localparam int NIBBLE_W = 4;
   localparam int POS_W    = 5;

   // Payload store: one entry per payload byte
   localparam int STORE_DEPTH = 15;
   localparam int IDX_W       = 4;
   localparam int LOW_BYTES   = 8;
   localparam int HIGH_BYTES  = STORE_DEPTH - LOW_BYTES;
   localparam int LOW_W       = LOW_BYTES * BYTE_W;
   localparam int HIGH_W      = HIGH_BYTES * BYTE_W;

   typedef logic [BYTE_W-1:0]   byte_type;
   typedef logic [NIBBLE_W-1:0] nibble_type;
   typedef logic [POS_W-1:0]    pos_type;
   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [LOW_W-1:0]    low_word_type;
   typedef logic [HIGH_W-1:0]   high_word_type;

   // Frame delimiters
   localparam byte_type FRAME_PREFIX  = 8'd137;
   localparam byte_type FRAME_TRAILER = 8'd138;

   // Frame positions: idle, header, then payload bytes from POS_FIRST on
   localparam pos_type POS_IDLE   = 5'd0;
   localparam pos_type POS_HEADER = 5'd1;
   localparam pos_type POS_FIRST  = 5'd2;

endpackage

>>> rtl/prefixed_frame_deframer.sv
// Prefixed frame deframer top level: byte-serial frame receiver with a
// registered result stage. Depends on pfd_pkg.
//
// The block takes one received byte per clock cycle, every cycle, as long
// as the result register is free or being emptied in the same cycle. While
// idle it skips bytes until the prefix 137; the next byte is a header (high
// nibble payload length 0..15, low nibble message type), then the payload
// bytes, then one trailer byte. A trailer equal to 138 loads one result into
// the output register at the edge that accepts it, so the result is offered
// in the next cycle; any other trailer drops the frame. Payload byte k sits
// at bits 8k of payload_low (bytes 0..7) or 8(k-8) of payload_high (bytes
// 8..14), and bytes at or past the length read as zero. The input stalls
// only while a finished result is waiting and the result side is stalling.
module prefixed_frame_deframer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  pfd_pkg::byte_type      req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output pfd_pkg::nibble_type    rsp_msg_type,
   output pfd_pkg::nibble_type    rsp_msg_size,
   output pfd_pkg::low_word_type  rsp_payload_low,
   output pfd_pkg::high_word_type rsp_payload_high
);
   import pfd_pkg::*;

   // Frame tracking state
   pos_type       frame_pos_ff, frame_pos_in;
   nibble_type    held_size_ff, held_size_in;
   nibble_type    held_type_ff, held_type_in;
   byte_type      store_ff [STORE_DEPTH];

   // Result register
   logic          rsp_valid_ff, rsp_valid_in;
   nibble_type    rsp_type_ff, rsp_size_ff;
   low_word_type  rsp_low_ff, low_in;
   high_word_type rsp_high_ff, high_in;

   logic          req_accept;
   logic          at_trailer;
   logic          store_we;
   logic          rsp_load;
   pos_type       trailer_pos;
   pos_type       slot_full;
   idx_type       slot;

   // Hold the input only while a result waits on a stalled output
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // Decode the frame position of the current word
   assign trailer_pos = pos_type'({1'b0, held_size_ff}) + POS_FIRST;
   assign at_trailer  = (frame_pos_ff >= POS_FIRST) && (frame_pos_ff >= trailer_pos);
   assign slot_full   = frame_pos_ff - POS_FIRST;
   assign slot        = slot_full[IDX_W-1:0];
   assign store_we    = req_accept && (frame_pos_ff >= POS_FIRST) && !at_trailer
                        && (slot_full < pos_type'(STORE_DEPTH));
   assign rsp_load    = req_accept && at_trailer && (req_rx_byte == FRAME_TRAILER);

   // Advance the frame position and capture the header
   always_comb begin
      frame_pos_in = frame_pos_ff;
      held_size_in = held_size_ff;
      held_type_in = held_type_ff;
      if (req_accept) begin
         if (frame_pos_ff == POS_IDLE) begin
            if (req_rx_byte == FRAME_PREFIX) begin
               frame_pos_in = POS_HEADER;
            end
         end else if (frame_pos_ff == POS_HEADER) begin
            held_size_in = req_rx_byte[BYTE_W-1:NIBBLE_W];
            held_type_in = req_rx_byte[NIBBLE_W-1:0];
            frame_pos_in = POS_FIRST;
         end else if (at_trailer) begin
            frame_pos_in = POS_IDLE;
         end else begin
            frame_pos_in = frame_pos_ff + pos_type'(1);
         end
      end
   end

   // Pack the stored payload, zeroing bytes at or past the length
   always_comb begin
      low_in  = '0;
      high_in = '0;
      for (int k = 0; k < LOW_BYTES; k++) begin
         if (idx_type'(k) < held_size_ff) begin
            low_in[k*BYTE_W +: BYTE_W] = store_ff[k];
         end
      end
      for (int k = 0; k < HIGH_BYTES; k++) begin
         if (idx_type'(LOW_BYTES + k) < held_size_ff) begin
            high_in[k*BYTE_W +: BYTE_W] = store_ff[LOW_BYTES + k];
         end
      end
   end

   // Drop the result once taken, load a new one on a good trailer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_pos_ff <= POS_IDLE;
         held_size_ff <= '0;
         held_type_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         frame_pos_ff <= frame_pos_in;
         held_size_ff <= held_size_in;
         held_type_ff <= held_type_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload store: write the current payload word into its slot
   always_ff @(posedge clock) begin
      for (int k = 0; k < STORE_DEPTH; k++) begin
         if (store_we && (slot == idx_type'(k))) begin
            store_ff[k] <= req_rx_byte;
         end
      end
   end

   // Result payload register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_type_ff <= held_type_ff;
         rsp_size_ff <= held_size_ff;
         rsp_low_ff  <= low_in;
         rsp_high_ff <= high_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_msg_type     = rsp_type_ff;
   assign rsp_msg_size     = rsp_size_ff;
   assign rsp_payload_low  = rsp_low_ff;
   assign rsp_payload_high = rsp_high_ff;

   // Position never runs past the trailer of the current frame
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      (frame_pos_ff >= POS_FIRST) |-> (frame_pos_ff <= trailer_pos))
      else $error("frame position beyond trailer");

   // Accepted trailer word always returns the block to idle
   a_trailer_idle: assert property (@(posedge clock) disable iff (reset)
      (req_accept && at_trailer) |=> (frame_pos_ff == POS_IDLE))
      else $error("no return to idle after trailer");

   // A fresh result only follows an accepted good trailer
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && rsp_stall))
      |-> $past(req_accept && at_trailer && (req_rx_byte == FRAME_TRAILER)))
      else $error("result without good trailer");

   // Empty frames carry an all-zero payload
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_size_ff == '0))
      |-> ((rsp_low_ff == '0) && (rsp_high_ff == '0)))
      else $error("nonzero payload in empty frame");

endmodule
